>>> design/bqlp_pkg.sv
// ----------------------------------------------------------------------------
// bqlp_pkg
// Shared widths, register indexes and word types of the interleaved biquad
// low-pass unit.
// ----------------------------------------------------------------------------
package bqlp_pkg;

   localparam int CHAN_BITS        = 3;
   localparam int SAMPLE_BITS      = 24;
   localparam int COEF_BITS        = 32;
   localparam int COEF_FRAC        = 28;
   localparam int PROD_BITS        = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS         = PROD_BITS + 3;
   localparam int SHIFT_BITS       = ACC_BITS - COEF_FRAC;
   localparam int DEF_NUM_CHANNELS = 8;
   localparam int FIFO_DEPTH       = 8;
   localparam int CSR_ADDR_BITS    = 5;
   localparam int CSR_DATA_BITS    = 32;
   localparam int REG_IDX_BITS     = CSR_ADDR_BITS - 2;

   localparam logic [REG_IDX_BITS-1:0] REG_COEF_X0 = REG_IDX_BITS'(0);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_X1 = REG_IDX_BITS'(1);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_X2 = REG_IDX_BITS'(2);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_Y1 = REG_IDX_BITS'(3);
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_Y2 = REG_IDX_BITS'(4);

   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [CHAN_BITS-1:0]          chan;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          block_end_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]          chan_out;
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          block_end_out;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x1;
      logic signed [SAMPLE_BITS-1:0] x2;
      logic signed [SAMPLE_BITS-1:0] y1;
      logic signed [SAMPLE_BITS-1:0] y2;
   } hist_type;

   typedef struct packed {
      logic                 en;
      logic [CHAN_BITS-1:0] chan;
      hist_type             data;
   } hist_wr_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] c_x0;
      logic signed [COEF_BITS-1:0] c_x1;
      logic signed [COEF_BITS-1:0] c_x2;
      logic signed [COEF_BITS-1:0] c_y1;
      logic signed [COEF_BITS-1:0] c_y2;
   } coef_set_type;

   typedef struct packed {
      logic                 valid;
      logic                 in_range;
      logic [CHAN_BITS-1:0] chan;
   } stage_tag_type;

endpackage

>>> design/bqlp_hist_mem.sv
// ----------------------------------------------------------------------------
// bqlp_hist_mem
// Per-channel history memory with a registered read port, one write port and
// a written flag per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module bqlp_hist_mem #(
   parameter int NUM_CHANNELS = bqlp_pkg::DEF_NUM_CHANNELS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [bqlp_pkg::CHAN_BITS-1:0] rd_chan,
   output bqlp_pkg::hist_type             rd_data,
   input  bqlp_pkg::hist_wr_type          wr
);

   localparam int ADDR_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   bqlp_pkg::hist_type     mem_ff [NUM_CHANNELS];
   bqlp_pkg::hist_type     rd_data_ff;
   logic                   rd_hit_ff;
   logic [NUM_CHANNELS-1:0] filled_ff;
   logic [NUM_CHANNELS-1:0] filled_in;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [ADDR_BITS-1:0]   wr_addr;

   assign rd_addr = ADDR_BITS'(rd_chan);
   assign wr_addr = ADDR_BITS'(wr.chan);

   always_comb begin
      filled_in = filled_ff;
      if (wr.en) begin
         filled_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
         if (rd_en) begin
            rd_hit_ff <= filled_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

>>> design/bqlp_mac_pipe.sv
// ----------------------------------------------------------------------------
// bqlp_mac_pipe
// Multiply-accumulate pipeline: five products, two partial sums, then the
// final difference, shift and saturation with the history write-back.
// ----------------------------------------------------------------------------
module bqlp_mac_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  bqlp_pkg::coef_set_type  coef,
   input  bqlp_pkg::stage_tag_type in_tag,
   input  bqlp_pkg::req_type       in_req,
   input  bqlp_pkg::hist_type      in_hist,
   output bqlp_pkg::stage_tag_type s2_tag,
   output logic                    out_valid,
   output bqlp_pkg::rsp_type       out_rsp,
   output bqlp_pkg::hist_wr_type   out_wr
);

   localparam int PROD_BITS   = bqlp_pkg::PROD_BITS;
   localparam int ACC_BITS    = bqlp_pkg::ACC_BITS;
   localparam int SHIFT_BITS  = bqlp_pkg::SHIFT_BITS;
   localparam int SAMPLE_BITS = bqlp_pkg::SAMPLE_BITS;
   localparam int COEF_FRAC   = bqlp_pkg::COEF_FRAC;

   logic signed [PROD_BITS-1:0]   prod_x0_in, prod_x1_in, prod_x2_in, prod_y1_in, prod_y2_in;
   logic signed [PROD_BITS-1:0]   prod_x0_ff, prod_x1_ff, prod_x2_ff, prod_y1_ff, prod_y2_ff;
   bqlp_pkg::stage_tag_type       s2_tag_ff;
   logic                          s2_block_end_ff;
   logic signed [SAMPLE_BITS-1:0] s2_x_ff, s2_x1_ff, s2_y1_ff;

   logic signed [ACC_BITS-1:0]    sum_x_in, sum_y_in;
   logic signed [ACC_BITS-1:0]    sum_x_ff, sum_y_ff;
   bqlp_pkg::stage_tag_type       s3_tag_ff;
   logic                          s3_block_end_ff;
   logic signed [SAMPLE_BITS-1:0] s3_x_ff, s3_x1_ff, s3_y1_ff;

   logic signed [ACC_BITS-1:0]    diff;
   logic signed [SHIFT_BITS-1:0]  shifted;
   logic [SHIFT_BITS-SAMPLE_BITS:0] top_bits;
   logic                          in_bounds;
   logic signed [SAMPLE_BITS-1:0] y_sat;

   assign prod_x0_in = PROD_BITS'(coef.c_x0) * PROD_BITS'(in_req.sample_in);
   assign prod_x1_in = PROD_BITS'(coef.c_x1) * PROD_BITS'(in_hist.x1);
   assign prod_x2_in = PROD_BITS'(coef.c_x2) * PROD_BITS'(in_hist.x2);
   assign prod_y1_in = PROD_BITS'(coef.c_y1) * PROD_BITS'(in_hist.y1);
   assign prod_y2_in = PROD_BITS'(coef.c_y2) * PROD_BITS'(in_hist.y2);

   always_ff @(posedge clock) begin
      prod_x0_ff      <= prod_x0_in;
      prod_x1_ff      <= prod_x1_in;
      prod_x2_ff      <= prod_x2_in;
      prod_y1_ff      <= prod_y1_in;
      prod_y2_ff      <= prod_y2_in;
      s2_block_end_ff <= in_req.block_end_in;
      s2_x_ff         <= in_req.sample_in;
      s2_x1_ff        <= in_hist.x1;
      s2_y1_ff        <= in_hist.y1;
   end

   assign sum_x_in = ACC_BITS'(prod_x0_ff) + ACC_BITS'(prod_x1_ff) + ACC_BITS'(prod_x2_ff);
   assign sum_y_in = ACC_BITS'(prod_y1_ff) + ACC_BITS'(prod_y2_ff);

   always_ff @(posedge clock) begin
      sum_x_ff        <= sum_x_in;
      sum_y_ff        <= sum_y_in;
      s3_block_end_ff <= s2_block_end_ff;
      s3_x_ff         <= s2_x_ff;
      s3_x1_ff        <= s2_x1_ff;
      s3_y1_ff        <= s2_y1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff.valid <= 1'b0;
         s3_tag_ff.valid <= 1'b0;
      end else begin
         s2_tag_ff <= in_tag;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   // The shifted sum fits the sample width when its upper bits are all sign.
   assign diff      = sum_x_ff - sum_y_ff;
   assign shifted   = diff[ACC_BITS-1:COEF_FRAC];
   assign top_bits  = shifted[SHIFT_BITS-1:SAMPLE_BITS-1];
   assign in_bounds = (&top_bits) || !(|top_bits);

   always_comb begin
      if (in_bounds) begin
         y_sat = shifted[SAMPLE_BITS-1:0];
      end else if (shifted[SHIFT_BITS-1]) begin
         y_sat = bqlp_pkg::SAT_MIN;
      end else begin
         y_sat = bqlp_pkg::SAT_MAX;
      end
   end

   assign s2_tag    = s2_tag_ff;
   assign out_valid = s3_tag_ff.valid;

   always_comb begin
      out_rsp.chan_out      = s3_tag_ff.chan;
      out_rsp.sample_out    = s3_tag_ff.in_range ? y_sat : '0;
      out_rsp.block_end_out = s3_block_end_ff;
      out_wr.en             = s3_tag_ff.valid && s3_tag_ff.in_range;
      out_wr.chan           = s3_tag_ff.chan;
      out_wr.data.x1        = s3_x_ff;
      out_wr.data.x2        = s3_x1_ff;
      out_wr.data.y1        = y_sat;
      out_wr.data.y2        = s3_y1_ff;
   end

endmodule

>>> design/bqlp_out_fifo.sv
// ----------------------------------------------------------------------------
// bqlp_out_fifo
// Result queue between the pipeline and the response channel.
// ----------------------------------------------------------------------------
module bqlp_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bqlp_pkg::rsp_type push_data,
   input  logic              pop_ready,
   output logic              out_valid,
   output bqlp_pkg::rsp_type out_data
);

   localparam int DEPTH    = bqlp_pkg::FIFO_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   bqlp_pkg::rsp_type    buf_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = buf_ff[rd_ptr_ff];
   assign pop       = out_valid && pop_ready;

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/multichannel_biquad_lowpass_unit.sv
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass_unit
// Channel-interleaved second-order low-pass filter, direct form 1.
// ----------------------------------------------------------------------------
// Each request word carries a channel number, a signed sample and a block-end
// flag; each response word carries the filtered, saturated sample with the
// channel number and flag copied. Five Q3.28 coefficients are written over the
// APB port; the user must write them only while the unit is idle, and the
// block itself does not enforce it. A word is read from the history memory at
// acceptance, and its result passes the stage-1, product and sum registers and
// the result queue before it is presented. Words on different channels are
// accepted one per cycle while fewer than eight words are pending. A word for
// the same channel as a word still in the stage-1 or product registers waits,
// so that the new output feeds the next product through the multiply and sum
// stages. Up to eight words may be pending; results wait in an eight-word queue
// while the receiver stalls, and request ready drops when eight are pending.
// Reset empties the pipeline and queue, clears all coefficients and marks
// every channel's history as zero.
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass_unit #(
   parameter int NUM_CHANNELS = bqlp_pkg::DEF_NUM_CHANNELS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bqlp_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bqlp_pkg::rsp_type                  rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bqlp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [bqlp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [bqlp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   localparam int PEND_BITS = $clog2(bqlp_pkg::FIFO_DEPTH + 1);

   bqlp_pkg::coef_set_type  coef_ff;
   logic [bqlp_pkg::REG_IDX_BITS-1:0] reg_idx;
   logic                    csr_write;

   logic                    req_accept;
   logic                    req_in_range;
   logic                    hazard;
   logic                    rsp_pop;
   logic [PEND_BITS-1:0]    pending_ff, pending_in;

   bqlp_pkg::stage_tag_type s1_tag_ff;
   bqlp_pkg::req_type       s1_req_ff;
   bqlp_pkg::stage_tag_type s2_tag;
   bqlp_pkg::hist_type      mem_rd_data;
   bqlp_pkg::hist_type      s1_hist;
   bqlp_pkg::hist_wr_type   pipe_wr;
   bqlp_pkg::hist_wr_type   wb_ff;
   logic                    pipe_valid;
   bqlp_pkg::rsp_type       pipe_rsp;

   // Configuration registers.
   assign pready    = 1'b1;
   assign reg_idx   = paddr[bqlp_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_write) begin
         case (reg_idx)
            bqlp_pkg::REG_COEF_X0: coef_ff.c_x0 <= pwdata;
            bqlp_pkg::REG_COEF_X1: coef_ff.c_x1 <= pwdata;
            bqlp_pkg::REG_COEF_X2: coef_ff.c_x2 <= pwdata;
            bqlp_pkg::REG_COEF_Y1: coef_ff.c_y1 <= pwdata;
            bqlp_pkg::REG_COEF_Y2: coef_ff.c_y2 <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         bqlp_pkg::REG_COEF_X0: prdata = coef_ff.c_x0;
         bqlp_pkg::REG_COEF_X1: prdata = coef_ff.c_x1;
         bqlp_pkg::REG_COEF_X2: prdata = coef_ff.c_x2;
         bqlp_pkg::REG_COEF_Y1: prdata = coef_ff.c_y1;
         bqlp_pkg::REG_COEF_Y2: prdata = coef_ff.c_y2;
         default:               prdata = '0;
      endcase
   end

   // Request side: credit for the result queue and the same-channel interlock.
   assign req_in_range = int'(req_data.chan) < NUM_CHANNELS;
   assign hazard = (s1_tag_ff.valid && s1_tag_ff.in_range && s1_tag_ff.chan == req_data.chan)
                || (s2_tag.valid && s2_tag.in_range && s2_tag.chan == req_data.chan);
   assign req_ready  = (pending_ff < PEND_BITS'(bqlp_pkg::FIFO_DEPTH)) && !hazard;
   assign req_accept = req_valid && req_ready;
   assign rsp_pop    = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + PEND_BITS'(req_accept) - PEND_BITS'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= '0;
         s1_tag_ff.valid <= 1'b0;
         wb_ff.en        <= 1'b0;
      end else begin
         pending_ff         <= pending_in;
         s1_tag_ff.valid    <= req_accept;
         s1_tag_ff.in_range <= req_in_range;
         s1_tag_ff.chan     <= req_data.chan;
         wb_ff              <= pipe_wr;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= req_data;
   end

   bqlp_hist_mem #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_hist_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept && req_in_range),
      .rd_chan (req_data.chan),
      .rd_data (mem_rd_data),
      .wr      (pipe_wr)
   );

   // A write that lands on the same edge as the read is taken from the
   // write-back register instead of the memory.
   assign s1_hist = (wb_ff.en && wb_ff.chan == s1_tag_ff.chan) ? wb_ff.data : mem_rd_data;

   bqlp_mac_pipe u_mac_pipe (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .in_tag    (s1_tag_ff),
      .in_req    (s1_req_ff),
      .in_hist   (s1_hist),
      .s2_tag    (s2_tag),
      .out_valid (pipe_valid),
      .out_rsp   (pipe_rsp),
      .out_wr    (pipe_wr)
   );

   bqlp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (pipe_valid),
      .push_data (pipe_rsp),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

>>> design/bqlp_port_checker.sv
// ----------------------------------------------------------------------------
// bqlp_port_checker
// Port-level checks of the interleaved biquad unit, bound to the top level.
// ----------------------------------------------------------------------------
module bqlp_port_checker #(
   parameter int NUM_CHANNELS = bqlp_pkg::DEF_NUM_CHANNELS
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bqlp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bqlp_pkg::rsp_type rsp_data
);

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A rising response valid must match a request accepted one pipeline depth earlier.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 4))
      else $error("response appeared without a request four cycles earlier");

   // Two words for the same in-range channel are never taken back to back.
   a_chan_interlock: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (int'(req_data.chan) < NUM_CHANNELS))
      |=> !(req_valid && req_ready && req_data.chan == $past(req_data.chan)))
      else $error("same channel accepted in consecutive cycles");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response word changed while stalled");

endmodule

bind multichannel_biquad_lowpass_unit bqlp_port_checker #(
   .NUM_CHANNELS(NUM_CHANNELS)
) u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
